// File: hw/rtl/md4_message_digest_top_macros.svh
// Assertion macros for the MD4 digest block.
`ifndef MD4_MESSAGE_DIGEST_TOP_MACROS_SVH
`define MD4_MESSAGE_DIGEST_TOP_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define MD4_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MD4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hw/rtl/md4_pkg.sv
// Shared types, constants and functions of the MD4 digest block.
package md4_pkg;
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] K1 = 32'h5a827999;
    localparam logic [31:0] K2 = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        DP_NOP   = 3'd0,
        DP_PUT   = 3'd1,
        DP_PAD   = 3'd2,
        DP_LEN   = 3'd3,
        DP_START = 3'd4,
        DP_ROUND = 3'd5,
        DP_FOLD  = 3'd6,
        DP_INIT  = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] pos;
        logic [7:0] data;
        logic [5:0] step;
        logic       zero_rest;
    } dp_cmd_t;

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] j;
        begin
            j = i[3:0];
            case (i[5:4])
                2'd0:    msg_index = j;
                2'd1:    msg_index = {j[1:0], j[3:2]};
                default: msg_index = {j[0], j[1], j[2], j[3]};
            endcase
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        begin
            case ({i[5:4], i[1:0]})
                4'b0000: rot_amount = 5'd3;
                4'b0001: rot_amount = 5'd7;
                4'b0010: rot_amount = 5'd11;
                4'b0011: rot_amount = 5'd19;
                4'b0100: rot_amount = 5'd3;
                4'b0101: rot_amount = 5'd5;
                4'b0110: rot_amount = 5'd9;
                4'b0111: rot_amount = 5'd13;
                4'b1000: rot_amount = 5'd3;
                4'b1001: rot_amount = 5'd9;
                4'b1010: rot_amount = 5'd11;
                default: rot_amount = 5'd15;
            endcase
        end
    endfunction
endpackage

// File: hw/rtl/md4_stream_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface md4_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface md4_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hw/rtl/md4_datapath.sv
// MD4 datapath: block buffer, chaining words and one compression step per cycle.
module md4_datapath
    import md4_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  dp_cmd_t       cmd,
    input  logic [60:0]   byte_count,
    input  logic [1:0]    out_sel,
    output logic [31:0]   out_word
);
    logic [31:0] block_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] f, t, rot;
    logic [31:0] k;
    logic [4:0]  s;
    logic [63:0] bits;

    assign bits = {byte_count, 3'b000};
    assign s = rot_amount(cmd.step);

    always_comb
    begin
        case (cmd.step[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f = b_reg ^ c_reg ^ d_reg;
        endcase
        case (cmd.step[5:4])
            2'd0:    k = 32'h0;
            2'd1:    k = K1;
            default: k = K2;
        endcase
        t = a_reg + f + block_reg[msg_index(cmd.step)] + k;
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    // block buffer: byte lanes written in place; stale lanes are always overwritten
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_PUT, DP_PAD:
            begin
                for (int w = 0; w < 16; w++)
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (6'(w * 4 + l) == cmd.pos)
                            block_reg[w][l*8 +: 8] <= (cmd.op == DP_PAD) ? PAD_BYTE : cmd.data;
                        else if (cmd.op == DP_PAD && cmd.zero_rest && 6'(w * 4 + l) > cmd.pos)
                            block_reg[w][l*8 +: 8] <= 8'h00;
                    end
                end
            end
            DP_LEN:
            begin
                for (int w = 0; w < 14; w++)
                begin
                    if (cmd.zero_rest)
                        block_reg[w] <= 32'h0;
                end
                block_reg[14] <= bits[31:0];
                block_reg[15] <= bits[63:32];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else
        begin
            case (cmd.op)
                DP_FOLD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                end
                DP_INIT:
                begin
                    chain_reg[0] <= INIT_A;
                    chain_reg[1] <= INIT_B;
                    chain_reg[2] <= INIT_C;
                    chain_reg[3] <= INIT_D;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_START:
            begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
            end
            DP_ROUND:
            begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= rot;
            end
            default:
            begin
            end
        endcase
    end

    assign out_word = chain_reg[out_sel];
endmodule

// File: hw/rtl/md4_control.sv
// MD4 controller: byte intake, padding sequence, round counter and digest output.
module md4_control
    import md4_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    md4_in_if.sink        in_ch,
    md4_out_if.source     out_ch,
    output dp_cmd_t       cmd,
    output logic [60:0]   byte_count,
    output logic [1:0]    out_sel,
    input  logic [31:0]   out_word
);
    `include "md4_message_digest_top_macros.svh"

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_PAD   = 8'b00000010,
        ST_LEN   = 8'b00000100,
        ST_START = 8'b00001000,
        ST_ROUND = 8'b00010000,
        ST_FOLD  = 8'b00100000,
        ST_OUT   = 8'b01000000,
        ST_INIT  = 8'b10000000
    } state_t;

    state_t      state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  step_reg, step_next;
    logic        fin_reg, fin_next;     // finishing message
    logic        last_blk_reg, last_blk_next; // this compression is the length block
    logic        extra_reg, extra_next; // length goes in a fresh block
    logic [1:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oword_reg;
    logic        in_fire, out_fire;
    logic [5:0]  used;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = ovalid_reg && out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign byte_count = count_reg;
    assign out_sel = idx_next;
    assign used = count_reg[5:0];

    assign out_ch.valid = ovalid_reg;
    assign out_ch.digest_word = oword_reg;
    assign out_ch.word_index = idx_reg;
    assign out_ch.last_word = (idx_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next = step_reg;
        fin_next = fin_reg;
        last_blk_next = last_blk_reg;
        extra_next = extra_reg;
        idx_next = idx_reg;
        ovalid_next = ovalid_reg;
        cmd = '{op: DP_NOP, pos: used, data: in_ch.data_byte, step: step_reg, zero_rest: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    fin_next = in_ch.end_of_message;
                    last_blk_next = 1'b0;
                    if (in_ch.has_byte)
                    begin
                        cmd.op = DP_PUT;
                        count_next = count_reg + 61'd1;
                        if (used == 6'd63)
                            state_next = ST_START;
                        else if (in_ch.end_of_message)
                            state_next = ST_PAD;
                    end
                    else if (in_ch.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                cmd.op = DP_PAD;
                cmd.zero_rest = 1'b1;
                extra_next = (used > 6'd55);
                state_next = (used > 6'd55) ? ST_START : ST_LEN;
            end
            ST_LEN:
            begin
                cmd.op = DP_LEN;
                cmd.zero_rest = extra_reg;
                last_blk_next = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.op = DP_START;
                step_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.op = DP_ROUND;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd47)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.op = DP_FOLD;
                if (last_blk_reg)
                begin
                    idx_next = 2'd0;
                    state_next = ST_OUT;
                end
                else if (fin_reg && extra_reg)
                    state_next = ST_LEN;
                else if (fin_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!ovalid_reg)
                    ovalid_next = 1'b1;
                else if (out_fire)
                begin
                    if (idx_reg == 2'd3)
                    begin
                        ovalid_next = 1'b0;
                        state_next = ST_INIT;
                    end
                    else
                        idx_next = idx_reg + 2'd1;
                end
            end
            ST_INIT:
            begin
                cmd.op = DP_INIT;
                count_next = 61'd0;
                fin_next = 1'b0;
                extra_next = 1'b0;
                last_blk_next = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // padding after a full block of message starts a fresh block
        if (state_reg == ST_FOLD && fin_reg && !last_blk_reg && !extra_reg)
            extra_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 61'd0;
            step_reg <= 6'd0;
            fin_reg <= 1'b0;
            last_blk_reg <= 1'b0;
            extra_reg <= 1'b0;
            idx_reg <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg <= step_next;
            fin_reg <= fin_next;
            last_blk_reg <= last_blk_next;
            extra_reg <= extra_next;
            idx_reg <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg <= out_word;
    end

    `MD4_ASSERT_IMP(a_no_intake_busy, clk, rst_n, ovalid_reg, !in_ch.ready,
        "input taken while digest pending")
    `MD4_ASSERT_NEXT(a_word_order, clk, rst_n, out_fire && idx_reg != 2'd3,
        ovalid_reg && idx_reg == $past(idx_reg) + 2'd1, "digest words out of order")
    `MD4_ASSERT_NEXT(a_count_cleared, clk, rst_n, out_fire && idx_reg == 2'd3,
        state_reg == ST_INIT, "no return to initial values after digest")
    `MD4_ASSERT_IMP(a_step_range, clk, rst_n, state_reg == ST_ROUND, step_reg < 6'd48,
        "round step beyond 47")
endmodule

// File: hw/rtl/md4_message_digest_top.sv
// MD4 digest block: streams message bytes in, four digest words out.
// Usage:
//   in_ch carries one item per transfer: data_byte with has_byte, and
//   end_of_message to close the message. out_ch returns four transfers per
//   message: digest words A, B, C, D with word_index and last_word on D.
// Timing:
//   A byte that neither fills a block nor ends the message leaves the input ready. A byte that completes a
//   64-byte block holds the input while the 48 compression steps run one per
//   cycle through a single step unit, plus start and fold.
//   Finishing takes one or two more compressions (a second when eight or fewer
//   bytes remain in the block); the fold then leads to the output state, which
//   raises valid for the first digest word, and words move at one per cycle
//   when out_ch is ready.
//   A stalled receiver holds the current word; no input is taken until all
//   four words have transferred, after which the chaining words and count
//   return to initial values.
// Reset:
//   rst_n clears the count and loads the initial chaining words at once.
module md4_message_digest_top
    import md4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    md4_in_if.sink     in_ch,
    md4_out_if.source  out_ch
);
    dp_cmd_t     cmd;
    logic [60:0] byte_count;
    logic [1:0]  out_sel;
    logic [31:0] out_word;

    md4_control u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cmd        (cmd),
        .byte_count (byte_count),
        .out_sel    (out_sel),
        .out_word   (out_word)
    );

    md4_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .byte_count (byte_count),
        .out_sel    (out_sel),
        .out_word   (out_word)
    );
endmodule

// File: sim/tb_md4_message_digest.sv
// Testbench for the MD4 digest block: directed table plus random messages.
`timescale 1ns / 100ps

module tb;
    import md4_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_item_t;

    typedef struct {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } digest_res_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
        logic       typed;
        logic [31:0] dig_a;
    } stim_row_t;

    logic clk;
    logic rst_n;

    md4_in_if  in_ch ();
    md4_out_if out_ch ();

    md4_message_digest_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Predictor state.
    logic [31:0] chain_q [4];
    logic [31:0] blk_q   [16];
    logic [60:0] count_q;

    digest_res_t digest_fifo [$];
    int          errors;
    int          words_seen;
    int          msgs_sent;
    longint      cycles;
    bit          hold_off;
    bit          sink_stall;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    function automatic void pred_reset();
        chain_q[0] = INIT_A;
        chain_q[1] = INIT_B;
        chain_q[2] = INIT_C;
        chain_q[3] = INIT_D;
        count_q = '0;
    endfunction

    function automatic void md4_put(input int pos, input logic [7:0] v);
        blk_q[(pos >> 2) & 15][(pos & 3) * 8 +: 8] = v;
    endfunction

    function automatic void md4_compress();
        int ord [48] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
                         0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
                         0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
        int rot [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
        logic [31:0] a, b, c, d, f, t, k;
        int r;
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (int i = 0; i < 48; i++)
        begin
            r = i >> 4;
            if (r == 0)
            begin
                f = (b & c) | (~b & d);
                k = 32'h0;
            end
            else if (r == 1)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K1;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K2;
            end
            t = a + f + blk_q[ord[i]] + k;
            t = (t << rot[r * 4 + (i & 3)]) | (t >> (32 - rot[r * 4 + (i & 3)]));
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
    endfunction

    // Advances the predictor by one accepted item; at end of message queues the digest words.
    function automatic void md4_absorb(input msg_item_t it);
        int used;
        logic [63:0] bits;
        digest_res_t r;
        if (it.has_byte)
        begin
            md4_put(int'(count_q[5:0]), it.data_byte);
            count_q = count_q + 61'd1;
            if (count_q[5:0] == 6'd0)
                md4_compress();
        end
        if (!it.end_of_message)
            return;
        used = int'(count_q[5:0]);
        md4_put(used, PAD_BYTE);
        for (int p = used + 1; p < 64; p++)
            md4_put(p, 8'h00);
        if (used + 1 > 56)
        begin
            md4_compress();
            for (int p = 0; p < 16; p++)
                blk_q[p] = '0;
        end
        bits = {count_q, 3'b000};
        blk_q[14] = bits[31:0];
        blk_q[15] = bits[63:32];
        md4_compress();
        for (int w = 0; w < 4; w++)
        begin
            r.digest_word = chain_q[w];
            r.word_index  = w[1:0];
            r.last_word   = (w == 3);
            digest_fifo.push_back(r);
        end
        pred_reset();
    endfunction

    task automatic send_item(input msg_item_t it);
        in_ch.valid          = 1'b1;
        in_ch.data_byte      = it.data_byte;
        in_ch.has_byte       = it.has_byte;
        in_ch.end_of_message = it.end_of_message;
        do
            @(posedge clk);
        while (!in_ch.ready);
        md4_absorb(it);
        if (it.end_of_message)
            msgs_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        repeat (g) @(negedge clk);
    endtask

    task automatic send_message(input int len);
        msg_item_t it;
        for (int i = 0; i < len; i++)
        begin
            // occasional idle items inside the message
            if ($urandom_range(0, 15) == 0)
            begin
                it.data_byte = 8'($urandom);
                it.has_byte = 1'b0;
                it.end_of_message = 1'b0;
                send_item(it);
            end
            it.data_byte = 8'($urandom);
            it.has_byte = 1'b1;
            it.end_of_message = (i == len - 1) && ($urandom_range(0, 1) == 0);
            send_item(it);
            if (it.end_of_message)
                return;
            random_gap();
        end
        it.data_byte = 8'($urandom);
        it.has_byte = 1'b0;
        it.end_of_message = 1'b1;
        send_item(it);
    endtask

    // Digest checker.
    always @(posedge clk)
    begin
        digest_res_t e;
        cycles <= cycles + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            words_seen++;
            if (digest_fifo.size() == 0)
                report_mismatch("unexpected word", out_ch.digest_word, 32'h0);
            else
            begin
                e = digest_fifo.pop_front();
                if (out_ch.digest_word !== e.digest_word)
                    report_mismatch("digest_word", out_ch.digest_word, e.digest_word);
                if (out_ch.word_index !== e.word_index)
                    report_mismatch("word_index", 32'(out_ch.word_index),
                                    32'(e.word_index));
                if (out_ch.last_word !== e.last_word)
                    report_mismatch("last_word", 32'(out_ch.last_word),
                                    32'(e.last_word));
            end
        end
    end

    // Receiver stall pattern.
    initial
    begin
        int g;
        sink_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 2) == 0)
            begin
                g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
                sink_stall = 1'b1;
                repeat (g) @(negedge clk);
                sink_stall = 1'b0;
            end
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    end

    always @(negedge clk)
        out_ch.ready <= !sink_stall && !hold_off;

    // Long receiver hold-off while the sender keeps offering items.
    initial
    begin
        hold_off = 1'b0;
        wait (msgs_sent == 10);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        if (cycles < 0)
            cycles = 0;
        wait (cycles > 1500000);
        $display("timeout at cycle %0d", cycles);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        // "abc" digest A word, empty message digest A word (RFC 1320)
        stim_row_t tbl [$];
        stim_row_t row;
        msg_item_t it;
        int len;
        errors = 0;
        words_seen = 0;
        msgs_sent = 0;
        cycles = 0;
        for (int p = 0; p < 16; p++)
            blk_q[p] = '0;
        pred_reset();
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        tbl.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 32'he0cfd631}); // empty message
        tbl.push_back('{8'hff, 1'b0, 1'b0, 1'b0, 32'h0});        // idle item
        tbl.push_back('{8'h61, 1'b1, 1'b0, 1'b0, 32'h0});
        tbl.push_back('{8'h62, 1'b1, 1'b0, 1'b0, 32'h0});
        tbl.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 32'h7a0148a4}); // "abc"
        tbl.push_back('{8'h00, 1'b1, 1'b1, 1'b0, 32'h0});
        tbl.push_back('{8'hff, 1'b1, 1'b1, 1'b0, 32'h0});
        tbl.push_back('{8'hff, 1'b1, 1'b0, 1'b0, 32'h0});
        tbl.push_back('{8'h00, 1'b0, 1'b1, 1'b0, 32'h0});
        foreach (tbl[i])
        begin
            row = tbl[i];
            it.data_byte = row.data_byte;
            it.has_byte = row.has_byte;
            it.end_of_message = row.end_of_message;
            send_item(it);
            if (row.typed && digest_fifo.size() == 4 && digest_fifo[0].digest_word !== row.dig_a)
                report_mismatch("predictor digest A", digest_fifo[0].digest_word, row.dig_a);
        end
        // padding boundaries: 55, 56, 64 bytes
        send_message(55);
        send_message(56);
        send_message(64);

        // random short messages
        for (int m = 0; m < 10; m++)
        begin
            len = $urandom_range(0, 5);
            send_message(len);
            random_gap();
        end

        while (digest_fifo.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d messages, checked %0d digest words", msgs_sent, words_seen);
        $display("covered empty, padding-boundary, multi-block and stalled-output cases");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
